// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/pfsc_pkg.sv =====
// Package for the priority flood block: sizes, codes, key type, helpers.
// No dependencies.
package pfsc_pkg;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int HEIGHT_BITS = 20;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CELL_W      = ROW_W + COL_W;
    localparam int NCELLS      = MAX_ROWS * MAX_COLS;
    localparam int KEY_W       = HEIGHT_BITS + CELL_W;
    localparam int CNT_W       = CELL_W + 1;
    localparam int DIM_W       = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [CELL_W-1:0] t_cell;

    // Clamp a size write into 1..lim.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] x;
        x = v;
        if (x == '0) x = DIM_W'(1);
        if (x > lim) x = lim;
        return x;
    endfunction
endpackage

// ===== hdl/pfsc_if.sv =====
// Valid/ready channel interfaces: requests, results, configuration writes.
// Depends on pfsc_pkg.
interface pfsc_req_if;
    import pfsc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [HEIGHT_BITS-1:0] height;
    modport source (output valid, req_type, row, col, height, input ready);
    modport sink   (input valid, req_type, row, col, height, output ready);
endinterface

interface pfsc_res_if;
    import pfsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] land_left;
    modport source (output valid, land_left, input ready);
    modport sink   (input valid, land_left, output ready);
endinterface

interface pfsc_cfg_if;
    import pfsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/priority_flood_sinking_count.sv =====
// Priority flood over a height grid; each advance raises the level (up to the top) and emits the land count.
// Load writes one height. Advance pops each queued cell at or below the raised level,
// sifts the heap down, and pushes each in-grid neighbour not yet queued, sifting it up.
// First advance seeds 2*(rows+cols) border slots, each followed by its push.
// Depends on pfsc_pkg and pfsc_if.
// Reset: synchronous; then a pass over every cell clears the queued map before requests are taken.
module priority_flood_sinking_count (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfsc_req_if.sink    i_req,
    pfsc_res_if.source  o_res,
    pfsc_cfg_if.sink    i_cfg
);
    import pfsc_pkg::*;

    // Sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_SEED = 5'd2,
                           S_CHK   = 5'd3,  S_TOP  = 5'd4,  S_LAST = 5'd5,
                           S_DN    = 5'd6,  S_DC1  = 5'd7,  S_DC2  = 5'd8,
                           S_DCMP  = 5'd9,  S_DWR  = 5'd10, S_NB   = 5'd11,
                           P_RD    = 5'd12, P_CHK  = 5'd13, P_UP   = 5'd14,
                           P_UPC   = 5'd15, P_WR   = 5'd16, S_OUT  = 5'd17;

    localparam logic [HEIGHT_BITS-1:0] LEVEL_TOP = '1;

    // Memories: heights, queued map (a flooded cell was queued first, so one
    // bit covers both), and the binary min-heap of {height, cell} keys.
    logic [HEIGHT_BITS-1:0] hmem [NCELLS];
    logic                   qmem [NCELLS];
    t_key                   heap [NCELLS];

    logic [HEIGHT_BITS-1:0] h_q;
    logic                   q_q;
    t_key                   heap_q;

    logic                   h_we;
    t_cell                  h_wa;
    logic                   q_we;
    t_cell                  q_wa;
    logic                   q_wd;
    logic                   heap_we;
    t_cell                  heap_wa;
    t_key                   heap_wd;
    t_cell                  heap_ra;

    // Control registers
    logic [4:0]             r_state, n_state;
    t_cell                  r_clr, n_clr;
    logic [DIM_W-1:0]       r_rows, n_rows, r_cols, n_cols;
    logic [CNT_W-1:0]       r_land, n_land;
    logic [HEIGHT_BITS-1:0] r_level, n_level;
    logic                   r_seeded, n_seeded;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_seeding, n_seeding;
    logic [DIM_W-1:0]       r_sidx, n_sidx;
    logic                   r_sside, n_sside, r_sphase, n_sphase, r_sdone, n_sdone;
    logic [2:0]             r_nb, n_nb;
    logic                   r_ovalid, n_ovalid;

    // Payload registers
    t_cell                  r_cell, n_cell;
    t_key                   r_key, n_key;
    t_cell                  r_k, n_k;
    t_key                   r_last, n_last;
    t_key                   r_min, n_min;
    t_cell                  r_ch, n_ch;
    t_cell                  r_top, n_top;
    logic [CNT_W-1:0]       r_oland, n_oland;

    logic                   req_acc;
    logic                   cfg_acc;
    logic [CNT_W-1:0]       ch_w;
    logic [CNT_W-1:0]       chp1_w;
    t_cell                  up_w;
    logic [DIM_W-1:0]       lim_w;
    logic [DIM_W-1:0]       sidx_p1;
    logic [ROW_W-1:0]       sd_row, nb_row;
    logic [COL_W-1:0]       sd_col, nb_col;
    logic                   nb_ok;
    logic [DIM_W-1:0]       cl_v;
    logic [2*DIM_W-1:0]     area_w;

    assign i_req.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_res.valid     = r_ovalid;
    assign o_res.land_left = r_oland;

    assign req_acc = i_req.valid & i_req.ready;
    assign cfg_acc = i_cfg.valid & i_cfg.ready;

    assign h_we = req_acc && (i_req.req_type == REQ_LOAD);
    assign h_wa = {i_req.row, i_req.col};

    assign ch_w    = {r_k, 1'b1};
    assign chp1_w  = {1'b0, r_ch} + CNT_W'(1);
    assign up_w    = (r_k - CELL_W'(1)) >> 1;
    assign lim_w   = r_sphase ? r_cols : r_rows;
    assign sidx_p1 = r_sidx + DIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (h_we) hmem[h_wa] <= i_req.height;
        h_q <= hmem[r_cell];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) qmem[q_wa] <= q_wd;
        q_q <= qmem[r_cell];
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) heap[heap_wa] <= heap_wd;
        heap_q <= heap[heap_ra];
    end

    // Border cell for the seed walk: rows down both side columns, then
    // columns across top and bottom rows.
    always_comb begin
        if (!r_sphase) begin
            sd_row = r_sidx[ROW_W-1:0];
            sd_col = r_sside ? COL_W'(r_cols - DIM_W'(1)) : '0;
        end else begin
            sd_row = r_sside ? ROW_W'(r_rows - DIM_W'(1)) : '0;
            sd_col = r_sidx[COL_W-1:0];
        end
    end

    // Neighbour of the popped cell selected by r_nb: up, left, down, right.
    always_comb begin
        nb_row = r_top[CELL_W-1:COL_W];
        nb_col = r_top[COL_W-1:0];
        nb_ok  = 1'b0;
        case (r_nb)
            3'd0: begin
                nb_ok  = (nb_row != '0);
                nb_row = nb_row - ROW_W'(1);
            end
            3'd1: begin
                nb_ok  = (nb_col != '0);
                nb_col = nb_col - COL_W'(1);
            end
            3'd2: begin
                nb_ok  = (({1'b0, nb_row} + DIM_W'(1)) < r_rows);
                nb_row = nb_row + ROW_W'(1);
            end
            3'd3: begin
                nb_ok  = (({1'b0, nb_col} + DIM_W'(1)) < r_cols);
                nb_col = nb_col + COL_W'(1);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_land    = r_land;
        n_level   = r_level;
        n_seeded  = r_seeded;
        n_cnt     = r_cnt;
        n_seeding = r_seeding;
        n_sidx    = r_sidx;
        n_sside   = r_sside;
        n_sphase  = r_sphase;
        n_sdone   = r_sdone;
        n_nb      = r_nb;
        n_ovalid  = r_ovalid;
        n_cell    = r_cell;
        n_key     = r_key;
        n_k       = r_k;
        n_last    = r_last;
        n_min     = r_min;
        n_ch      = r_ch;
        n_top     = r_top;
        n_oland   = r_oland;
        q_we      = 1'b0;
        q_wa      = r_cell;
        q_wd      = 1'b1;
        heap_we   = 1'b0;
        heap_wa   = r_k;
        heap_wd   = r_key;
        heap_ra   = '0;
        cl_v      = '0;
        area_w    = '0;

        if (r_ovalid && o_res.ready) n_ovalid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                q_we  = 1'b1;
                q_wa  = r_clr;
                q_wd  = 1'b0;
                n_clr = r_clr + CELL_W'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_acc && i_req.req_type == REQ_ADVANCE) begin
                    if (r_level != LEVEL_TOP) n_level = r_level + HEIGHT_BITS'(1);
                    if (!r_seeded) begin
                        n_seeded  = 1'b1;
                        n_seeding = 1'b1;
                        n_sidx    = '0;
                        n_sside   = 1'b0;
                        n_sphase  = 1'b0;
                        n_sdone   = 1'b0;
                        n_state   = S_SEED;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_SEED: begin
                if (r_sdone) begin
                    n_seeding = 1'b0;
                    n_state   = S_CHK;
                end else begin
                    n_cell  = {sd_row, sd_col};
                    n_state = P_RD;
                    n_sside = ~r_sside;
                    if (r_sside) begin
                        n_sidx = sidx_p1;
                        if (sidx_p1 == lim_w) begin
                            n_sidx   = '0;
                            n_sphase = 1'b1;
                            if (r_sphase) n_sdone = 1'b1;
                        end
                    end
                end
            end
            // Push: test queued bit, then sift the new key up.
            P_RD: n_state = P_CHK;
            P_CHK: begin
                if (q_q || r_cnt == CNT_W'(NCELLS)) begin
                    n_state = r_seeding ? S_SEED : S_NB;
                end else begin
                    q_we    = 1'b1;
                    n_key   = {h_q, r_cell};
                    n_k     = r_cnt[CELL_W-1:0];
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = P_UP;
                end
            end
            P_UP: begin
                heap_ra = up_w;
                n_state = (r_k == '0) ? P_WR : P_UPC;
            end
            P_UPC: begin
                if (heap_q <= r_key) begin
                    n_state = P_WR;
                end else begin
                    heap_we = 1'b1;
                    heap_wd = heap_q;
                    n_k     = up_w;
                    n_state = P_UP;
                end
            end
            P_WR: begin
                heap_we = 1'b1;
                heap_wd = r_key;
                n_state = r_seeding ? S_SEED : S_NB;
            end
            // Pop while the lowest queued height is at or below the level.
            S_CHK: begin
                heap_ra = '0;
                n_state = (r_cnt == '0) ? S_OUT : S_TOP;
            end
            S_TOP: begin
                if (heap_q[KEY_W-1:CELL_W] <= r_level) begin
                    n_top   = heap_q[CELL_W-1:0];
                    n_cnt   = r_cnt - CNT_W'(1);
                    heap_ra = n_cnt[CELL_W-1:0];
                    n_state = S_LAST;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LAST: begin
                n_last  = heap_q;
                n_k     = '0;
                n_state = S_DN;
            end
            S_DN: begin
                heap_ra = ch_w[CELL_W-1:0];
                n_ch    = ch_w[CELL_W-1:0];
                n_state = (ch_w >= r_cnt) ? S_DWR : S_DC1;
            end
            S_DC1: begin
                n_min   = heap_q;
                heap_ra = chp1_w[CELL_W-1:0];
                n_state = (chp1_w < r_cnt) ? S_DC2 : S_DCMP;
            end
            S_DC2: begin
                if (heap_q < r_min) begin
                    n_min = heap_q;
                    n_ch  = chp1_w[CELL_W-1:0];
                end
                n_state = S_DCMP;
            end
            S_DCMP: begin
                if (r_last <= r_min) begin
                    n_state = S_DWR;
                end else begin
                    heap_we = 1'b1;
                    heap_wd = r_min;
                    n_k     = r_ch;
                    n_state = S_DN;
                end
            end
            S_DWR: begin
                heap_we = 1'b1;
                heap_wd = r_last;
                if (r_land != '0) n_land = r_land - CNT_W'(1);
                n_nb    = '0;
                n_state = S_NB;
            end
            S_NB: begin
                if (r_nb == 3'd4) begin
                    n_state = S_CHK;
                end else begin
                    n_nb = r_nb + 3'd1;
                    if (nb_ok) begin
                        n_cell  = {nb_row, nb_col};
                        n_state = P_RD;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_oland  = r_land;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Size writes before seeding; later ones are dropped.
        if (cfg_acc && !r_seeded) begin
            if (i_cfg.index == CFG_ROWS) begin
                cl_v   = clamp_dim(i_cfg.data, DIM_W'(MAX_ROWS));
                n_rows = cl_v;
                area_w = cl_v * r_cols;
                n_land = area_w[CNT_W-1:0];
            end else if (i_cfg.index == CFG_COLS) begin
                cl_v   = clamp_dim(i_cfg.data, DIM_W'(MAX_COLS));
                n_cols = cl_v;
                area_w = r_rows * cl_v;
                n_land = area_w[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_rows    <= DIM_W'(MAX_ROWS);
            r_cols    <= DIM_W'(MAX_COLS);
            r_land    <= CNT_W'(MAX_ROWS * MAX_COLS);
            r_level   <= '0;
            r_seeded  <= 1'b0;
            r_cnt     <= '0;
            r_seeding <= 1'b0;
            r_sidx    <= '0;
            r_sside   <= 1'b0;
            r_sphase  <= 1'b0;
            r_sdone   <= 1'b0;
            r_nb      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_land    <= n_land;
            r_level   <= n_level;
            r_seeded  <= n_seeded;
            r_cnt     <= n_cnt;
            r_seeding <= n_seeding;
            r_sidx    <= n_sidx;
            r_sside   <= n_sside;
            r_sphase  <= n_sphase;
            r_sdone   <= n_sdone;
            r_nb      <= n_nb;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell  <= n_cell;
        r_key   <= n_key;
        r_k     <= n_k;
        r_last  <= n_last;
        r_min   <= n_min;
        r_ch    <= n_ch;
        r_top   <= n_top;
        r_oland <= n_oland;
    end
endmodule

// ===== hdl/pfsc_checker.sv =====
// Port-level checks for the priority flood block, bound to the top level.
// Depends on pfsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pfsc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         req_type,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [pfsc_pkg::CNT_W-1:0]   land_left
);
    import pfsc_pkg::*;

    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid)
    `ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, res_valid && !res_ready, $stable(land_left))
    `ASSERT_SAME(a_land_max, i_clk, i_rst_n, res_valid, land_left <= CNT_W'(NCELLS))
    `ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, req_valid && req_ready && req_type == REQ_LOAD, req_ready)
    `ASSERT_NEXT(a_adv_busy, i_clk, i_rst_n, req_valid && req_ready && req_type == REQ_ADVANCE, !req_ready)
endmodule

bind priority_flood_sinking_count pfsc_checker u_pfsc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .req_type  (i_req.req_type),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .land_left (o_res.land_left)
);
